@@ src/spma_pkg.sv @@
// Shared types and constants for the sparse polynomial merge-add block.
package spma_pkg;

  localparam int unsigned MaxTerms = 16;
  // count holds 0..MaxTerms, index holds 0..MaxTerms-1
  localparam int unsigned CntW = $clog2(MaxTerms + 1);
  localparam int unsigned IdxW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;

  localparam int unsigned CoefW    = 16;
  localparam int unsigned ExpoW    = 8;
  localparam int unsigned SumCoefW = CoefW + 1;

  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic        [ExpoW-1:0] expo;
  } term_t;

  // input word modes
  localparam logic [1:0] ModeAppendA = 2'd0;
  localparam logic [1:0] ModeAppendB = 2'd1;
  localparam logic [1:0] ModeAdd     = 2'd2;

  // output word kinds
  localparam logic [1:0] KindOk    = 2'd0;
  localparam logic [1:0] KindFull  = 2'd1;
  localparam logic [1:0] KindTerm  = 2'd2;
  localparam logic [1:0] KindEmpty = 2'd3;

endpackage

@@ src/sparse_polynomial_merge_add.sv @@
// Top level: sparse polynomial term lists in two RAMs and a merging adder.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------------
//  in      | input     | in_valid_i / in_ready_o  | mode_i, coefficient_i, exponent_i
//  out     | output    | out_valid_o / out_ready_i| kind_o, sum_coefficient_o, sum_exponent_o,
//          |           |                          | last_o
//
// Flow: an append is answered with a single word and an unused mode is swallowed with
// no answer; appends stream back to back while the output is taken. An add first reads
// both list RAMs synchronously, then gives one merged term per cycle unless the output
// stalls, paced by the one read port of each RAM. An add on two empty lists gives one Empty word.
// Reset: only counts, the merge state and the output valid are cleared; the RAMs need
// no clearing since only entries below a count are ever used.
// Stalls: a held output word freezes the merge; the read addresses are reissued so the
// RAM read data stays put. No new word is taken while a merge is in progress.
module sparse_polynomial_merge_add (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            mode_i,
  input  logic signed [spma_pkg::CoefW-1:0]     coefficient_i,
  input  logic [spma_pkg::ExpoW-1:0]            exponent_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            kind_o,
  output logic signed [spma_pkg::SumCoefW-1:0]  sum_coefficient_o,
  output logic [spma_pkg::ExpoW-1:0]            sum_exponent_o,
  output logic                                  last_o
);

  localparam int unsigned CntW     = spma_pkg::CntW;
  localparam int unsigned IdxW     = spma_pkg::IdxW;
  localparam int unsigned SumCoefW = spma_pkg::SumCoefW;

  // merge sequencer states
  localparam logic StIdle  = 1'b0;
  localparam logic StMerge = 1'b1;

  // term list RAMs, one synchronous read port each
  spma_pkg::term_t mem_a [spma_pkg::MaxTerms];
  spma_pkg::term_t mem_b [spma_pkg::MaxTerms];
  spma_pkg::term_t rd_a_q, rd_b_q;

  logic            state_q, state_d;
  logic [CntW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;   // merge read pointers

  logic                                 out_valid_q, out_valid_d;
  logic [1:0]                           kind_q, kind_d;
  logic signed [spma_pkg::SumCoefW-1:0] coef_q, coef_d;
  logic [spma_pkg::ExpoW-1:0]           expo_q, expo_d;
  logic                                 last_q, last_d;

  logic            slot_free, in_fire, we_a, we_b;
  logic            full_a, full_b, a_left, b_left, take_a, take_b;
  spma_pkg::term_t wr_term;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign full_a  = (cnt_a_q == CntW'(spma_pkg::MaxTerms));
  assign full_b  = (cnt_b_q == CntW'(spma_pkg::MaxTerms));
  assign a_left  = (i_q < cnt_a_q);
  assign b_left  = (j_q < cnt_b_q);
  assign wr_term = '{coef: coefficient_i, expo: exponent_i};

  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    i_d         = i_q;
    j_d         = j_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    coef_d      = coef_q;
    expo_d      = expo_q;
    last_d      = last_q;
    we_a        = 1'b0;
    we_b        = 1'b0;
    take_a      = 1'b0;
    take_b      = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          case (mode_i)
            spma_pkg::ModeAppendA: begin
              out_valid_d = 1'b1;
              kind_d      = full_a ? spma_pkg::KindFull : spma_pkg::KindOk;
              coef_d      = '0;
              expo_d      = '0;
              last_d      = 1'b1;
              we_a        = !full_a;
              if (!full_a) begin
                cnt_a_d = cnt_a_q + CntW'(1);
              end
            end
            spma_pkg::ModeAppendB: begin
              out_valid_d = 1'b1;
              kind_d      = full_b ? spma_pkg::KindFull : spma_pkg::KindOk;
              coef_d      = '0;
              expo_d      = '0;
              last_d      = 1'b1;
              we_b        = !full_b;
              if (!full_b) begin
                cnt_b_d = cnt_b_q + CntW'(1);
              end
            end
            spma_pkg::ModeAdd: begin
              i_d = '0;
              j_d = '0;
              if (cnt_a_q == '0 && cnt_b_q == '0) begin
                out_valid_d = 1'b1;
                kind_d      = spma_pkg::KindEmpty;
                coef_d      = '0;
                expo_d      = '0;
                last_d      = 1'b1;
              end else begin
                state_d = StMerge;
              end
            end
            default: ;  // unused mode: swallowed, no answer
          endcase
        end
      end
      StMerge: begin
        // RAM read data belongs to (i_q, j_q) here
        if (slot_free) begin
          if (a_left && b_left) begin
            take_a = (rd_a_q.expo >= rd_b_q.expo);
            take_b = (rd_b_q.expo >= rd_a_q.expo);
          end else begin
            take_a = a_left;
            take_b = !a_left;
          end
          coef_d = (take_a ? SumCoefW'(rd_a_q.coef) : '0)
                 + (take_b ? SumCoefW'(rd_b_q.coef) : '0);
          expo_d = take_a ? rd_a_q.expo : rd_b_q.expo;
          i_d    = take_a ? i_q + CntW'(1) : i_q;
          j_d    = take_b ? j_q + CntW'(1) : j_q;
          out_valid_d = 1'b1;
          kind_d      = spma_pkg::KindTerm;
          last_d      = (i_d >= cnt_a_q) && (j_d >= cnt_b_q);
          if (last_d) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // RAMs: write on append, read the next pointers every cycle
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[cnt_a_q[IdxW-1:0]] <= wr_term;
    end
    if (we_b) begin
      mem_b[cnt_b_q[IdxW-1:0]] <= wr_term;
    end
    rd_a_q <= mem_a[i_d[IdxW-1:0]];
    rd_b_q <= mem_b[j_d[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    coef_q <= coef_d;
    expo_q <= expo_d;
    last_q <= last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign sum_coefficient_o = coef_q;
  assign sum_exponent_o    = expo_q;
  assign last_o            = last_q;

endmodule

@@ src/spma_chk.sv @@
// Port-level checker for the sparse polynomial merge-add block, with its bind.
module spma_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic [1:0]                            mode_i,
  input logic signed [spma_pkg::CoefW-1:0]     coefficient_i,
  input logic [spma_pkg::ExpoW-1:0]            exponent_i,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic [1:0]                            kind_o,
  input logic signed [spma_pkg::SumCoefW-1:0]  sum_coefficient_o,
  input logic [spma_pkg::ExpoW-1:0]            sum_exponent_o,
  input logic                                  last_o
);

  // held output word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(sum_coefficient_o) && $stable(sum_exponent_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // an append answers in the very next cycle with a single word
  a_append_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o
      && (mode_i == spma_pkg::ModeAppendA || mode_i == spma_pkg::ModeAppendB)
    |=> out_valid_o && last_o
      && (kind_o == spma_pkg::KindOk || kind_o == spma_pkg::KindFull))
    else $error("append not answered next cycle");

  // only sum terms carry a coefficient and exponent; every other word has last set
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != spma_pkg::KindTerm
    |-> sum_coefficient_o == '0 && sum_exponent_o == '0 && last_o)
    else $error("non-term word with payload or without last");

  // mid-sum, no new input word is taken
  a_busy_mid_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input taken during a merge");

endmodule

bind sparse_polynomial_merge_add spma_chk u_spma_chk (.*);
